### hw/rtl/rmd160_pkg.sv
// ----------------------------------------------------------------------------
// RIPEMD-160 package
// Shared types, constants and step functions for the hash core.
// ----------------------------------------------------------------------------
package rmd160_pkg;

    // Initial chaining words.
    localparam logic [31:0] IV0 = 32'h67452301;
    localparam logic [31:0] IV1 = 32'hEFCDAB89;
    localparam logic [31:0] IV2 = 32'h98BADCFE;
    localparam logic [31:0] IV3 = 32'h10325476;
    localparam logic [31:0] IV4 = 32'hC3D2E1F0;

    localparam int STEPS = 80;

    // Sequencer states of the core.
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_PAD,
        ST_COMP,
        ST_EMIT
    } state_t;

    // Request from the controller to the round engine.
    typedef struct packed {
        logic start;
    } eng_ctrl_t;

    // Status from the round engine.
    typedef struct packed {
        logic busy;
        logic done;
    } eng_stat_t;

    // Message word selection, left line.
    function automatic logic [3:0] word_l(input logic [6:0] j);
        logic [3:0] r;
        logic [3:0] t0 [16];
        logic [3:0] t1 [16];
        logic [3:0] t2 [16];
        logic [3:0] t3 [16];
        t0 = '{4'd7,4'd4,4'd13,4'd1,4'd10,4'd6,4'd15,4'd3,
               4'd12,4'd0,4'd9,4'd5,4'd2,4'd14,4'd11,4'd8};
        t1 = '{4'd3,4'd10,4'd14,4'd4,4'd9,4'd15,4'd8,4'd1,
               4'd2,4'd7,4'd0,4'd6,4'd13,4'd11,4'd5,4'd12};
        t2 = '{4'd1,4'd9,4'd11,4'd10,4'd0,4'd8,4'd12,4'd4,
               4'd13,4'd3,4'd7,4'd15,4'd14,4'd5,4'd6,4'd2};
        t3 = '{4'd4,4'd0,4'd5,4'd9,4'd7,4'd12,4'd2,4'd10,
               4'd14,4'd1,4'd3,4'd8,4'd11,4'd6,4'd15,4'd13};
        unique case (j[6:4])
            3'd0: r = j[3:0];
            3'd1: r = t0[j[3:0]];
            3'd2: r = t1[j[3:0]];
            3'd3: r = t2[j[3:0]];
            default: r = t3[j[3:0]];
        endcase
        return r;
    endfunction

    // Message word selection, right line.
    function automatic logic [3:0] word_r(input logic [6:0] j);
        logic [3:0] r;
        logic [3:0] t0 [16];
        logic [3:0] t1 [16];
        logic [3:0] t2 [16];
        logic [3:0] t3 [16];
        logic [3:0] t4 [16];
        t0 = '{4'd5,4'd14,4'd7,4'd0,4'd9,4'd2,4'd11,4'd4,
               4'd13,4'd6,4'd15,4'd8,4'd1,4'd10,4'd3,4'd12};
        t1 = '{4'd6,4'd11,4'd3,4'd7,4'd0,4'd13,4'd5,4'd10,
               4'd14,4'd15,4'd8,4'd12,4'd4,4'd9,4'd1,4'd2};
        t2 = '{4'd15,4'd5,4'd1,4'd3,4'd7,4'd14,4'd6,4'd9,
               4'd11,4'd8,4'd12,4'd2,4'd10,4'd0,4'd4,4'd13};
        t3 = '{4'd8,4'd6,4'd4,4'd1,4'd3,4'd11,4'd15,4'd0,
               4'd5,4'd12,4'd2,4'd13,4'd9,4'd7,4'd10,4'd14};
        t4 = '{4'd12,4'd15,4'd10,4'd4,4'd1,4'd5,4'd8,4'd7,
               4'd6,4'd2,4'd13,4'd14,4'd0,4'd3,4'd9,4'd11};
        unique case (j[6:4])
            3'd0: r = t0[j[3:0]];
            3'd1: r = t1[j[3:0]];
            3'd2: r = t2[j[3:0]];
            3'd3: r = t3[j[3:0]];
            default: r = t4[j[3:0]];
        endcase
        return r;
    endfunction

    // Rotation amount, left line.
    function automatic logic [3:0] rot_l(input logic [6:0] j);
        logic [3:0] t [80];
        t = '{4'd11,4'd14,4'd15,4'd12,4'd5,4'd8,4'd7,4'd9,
              4'd11,4'd13,4'd14,4'd15,4'd6,4'd7,4'd9,4'd8,
              4'd7,4'd6,4'd8,4'd13,4'd11,4'd9,4'd7,4'd15,
              4'd7,4'd12,4'd15,4'd9,4'd11,4'd7,4'd13,4'd12,
              4'd11,4'd13,4'd6,4'd7,4'd14,4'd9,4'd13,4'd15,
              4'd14,4'd8,4'd13,4'd6,4'd5,4'd12,4'd7,4'd5,
              4'd11,4'd12,4'd14,4'd15,4'd14,4'd15,4'd9,4'd8,
              4'd9,4'd14,4'd5,4'd6,4'd8,4'd6,4'd5,4'd12,
              4'd9,4'd15,4'd5,4'd11,4'd6,4'd8,4'd13,4'd12,
              4'd5,4'd12,4'd13,4'd14,4'd11,4'd8,4'd5,4'd6};
        return (j < 7'd80) ? t[j] : 4'd0;
    endfunction

    // Rotation amount, right line.
    function automatic logic [3:0] rot_r(input logic [6:0] j);
        logic [3:0] t [80];
        t = '{4'd8,4'd9,4'd9,4'd11,4'd13,4'd15,4'd15,4'd5,
              4'd7,4'd7,4'd8,4'd11,4'd14,4'd14,4'd12,4'd6,
              4'd9,4'd13,4'd15,4'd7,4'd12,4'd8,4'd9,4'd11,
              4'd7,4'd7,4'd12,4'd7,4'd6,4'd15,4'd13,4'd11,
              4'd9,4'd7,4'd15,4'd11,4'd8,4'd6,4'd6,4'd14,
              4'd12,4'd13,4'd5,4'd14,4'd13,4'd13,4'd7,4'd5,
              4'd15,4'd5,4'd8,4'd11,4'd14,4'd14,4'd6,4'd14,
              4'd6,4'd9,4'd12,4'd9,4'd12,4'd5,4'd15,4'd8,
              4'd8,4'd5,4'd12,4'd9,4'd12,4'd5,4'd14,4'd6,
              4'd8,4'd13,4'd6,4'd5,4'd15,4'd13,4'd11,4'd11};
        return (j < 7'd80) ? t[j] : 4'd0;
    endfunction

    // Additive constants per group of sixteen steps.
    function automatic logic [31:0] k_l(input logic [2:0] g);
        logic [31:0] r;
        unique case (g)
            3'd0: r = 32'h00000000;
            3'd1: r = 32'h5A827999;
            3'd2: r = 32'h6ED9EBA1;
            3'd3: r = 32'h8F1BBCDC;
            default: r = 32'hA953FD4E;
        endcase
        return r;
    endfunction

    function automatic logic [31:0] k_r(input logic [2:0] g);
        logic [31:0] r;
        unique case (g)
            3'd0: r = 32'h50A28BE6;
            3'd1: r = 32'h5C4DD124;
            3'd2: r = 32'h6D703EF3;
            3'd3: r = 32'h7A6D76E9;
            default: r = 32'h00000000;
        endcase
        return r;
    endfunction

    // Boolean function of a group.
    function automatic logic [31:0] bool_f(input logic [2:0] g, input logic [31:0] x,
                                           input logic [31:0] y, input logic [31:0] z);
        logic [31:0] r;
        unique case (g)
            3'd0: r = x ^ y ^ z;
            3'd1: r = (x & y) | (~x & z);
            3'd2: r = (x | ~y) ^ z;
            3'd3: r = (x & z) | (y & ~z);
            default: r = x ^ (y | ~z);
        endcase
        return r;
    endfunction

    // Rotate left by up to fifteen places.
    function automatic logic [31:0] rotl(input logic [31:0] x, input logic [3:0] n);
        logic [63:0] d;
        d = {x, x} << n;
        return d[63:32];
    endfunction

endpackage

### hw/rtl/rmd160_rounds.sv
// ----------------------------------------------------------------------------
// RIPEMD-160 round engine
// Runs one step of both lines per cycle, 80 steps, then folds the result into
// the chaining value.
// ----------------------------------------------------------------------------
module rmd160_rounds
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  rmd160_pkg::eng_ctrl_t  ctrl,
    input  logic                   cv_init,
    input  logic [511:0]           block,
    output rmd160_pkg::eng_stat_t  stat,
    output logic [159:0]           cv
);
    import rmd160_pkg::*;

    logic [31:0] cv_reg [5];
    logic [31:0] l_reg [5];
    logic [31:0] r_reg [5];
    logic [6:0]  step_reg;
    logic        busy_reg;
    logic        done_reg;

    logic [2:0]  grp;
    logic [31:0] wl;
    logic [31:0] wr;
    logic [31:0] tl;
    logic [31:0] tr;
    logic [3:0]  il;
    logic [3:0]  ir;

    // Step datapath of both lines, shared by every step.
    always_comb
    begin
        grp = step_reg[6:4];
        il  = word_l(step_reg);
        ir  = word_r(step_reg);
        wl  = block[{il, 5'd0} +: 32];
        wr  = block[{ir, 5'd0} +: 32];
        tl  = rotl(l_reg[0] + bool_f(grp, l_reg[1], l_reg[2], l_reg[3]) + wl + k_l(grp),
                   rot_l(step_reg)) + l_reg[4];
        tr  = rotl(r_reg[0] + bool_f(3'd4 - grp, r_reg[1], r_reg[2], r_reg[3]) + wr
                   + k_r(grp), rot_r(step_reg)) + r_reg[4];
    end

    // Control of the step counter.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (ctrl.start)
            begin
                busy_reg <= 1'b1;
                step_reg <= '0;
            end
            else if (busy_reg)
            begin
                if (step_reg == 7'(STEPS - 1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
                step_reg <= step_reg + 7'd1;
            end
        end
    end

    // Working registers and chaining value.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cv_reg <= '{IV0, IV1, IV2, IV3, IV4};
            l_reg  <= '{'0, '0, '0, '0, '0};
            r_reg  <= '{'0, '0, '0, '0, '0};
        end
        else if (cv_init)
        begin
            cv_reg <= '{IV0, IV1, IV2, IV3, IV4};
        end
        else if (ctrl.start)
        begin
            l_reg <= cv_reg;
            r_reg <= cv_reg;
        end
        else if (busy_reg)
        begin
            l_reg <= '{l_reg[4], tl, l_reg[1], rotl(l_reg[2], 4'd10), l_reg[3]};
            r_reg <= '{r_reg[4], tr, r_reg[1], rotl(r_reg[2], 4'd10), r_reg[3]};
        end
        else if (done_reg)
        begin
            cv_reg[0] <= cv_reg[1] + l_reg[2] + r_reg[3];
            cv_reg[1] <= cv_reg[2] + l_reg[3] + r_reg[4];
            cv_reg[2] <= cv_reg[3] + l_reg[4] + r_reg[0];
            cv_reg[3] <= cv_reg[4] + l_reg[0] + r_reg[1];
            cv_reg[4] <= cv_reg[0] + l_reg[1] + r_reg[2];
        end
    end

    assign stat.busy = busy_reg | ctrl.start;
    assign stat.done = done_reg;
    assign cv = {cv_reg[4], cv_reg[3], cv_reg[2], cv_reg[1], cv_reg[0]};

endmodule

### hw/rtl/ripemd160_hash_core.sv
// ----------------------------------------------------------------------------
// RIPEMD-160 hash core
// Byte stream in, five digest words out.
// ----------------------------------------------------------------------------
// Bytes are taken only while idle; the 64th byte of a block starts a
// compression (80 steps in the shared round unit, then a fold).
// A last word pads one byte per cycle, compresses once or twice, then emits
// five digest words, one per accepted output word.
// Reset (rst_n low, asynchronous) restores the initial chaining value and
// clears the byte count, bit length and output valid.
module ripemd160_hash_core
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] data_byte
    input  logic        s_tuser,   // has_byte
    input  logic        s_tlast,   // last
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [39:0] m_tdata,   // [31:0] digest_word, [34:32] word_index, zeros
    output logic        m_tlast    // last_word
);
    import rmd160_pkg::*;

    state_t       state_reg, state_next;
    logic [31:0]  buf_reg [16];
    logic [5:0]   fill_reg, fill_next;
    logic [63:0]  len_reg, len_next, bits_reg, bits_next;
    logic         fin_reg, fin_next;
    logic [2:0]   widx_reg, widx_next;
    logic         pad_live_reg, pad_live_next;
    logic         pad_done_reg, pad_done_next;
    logic         len_here_reg, len_here_next;
    logic         wr_en;
    logic [7:0]   wr_byte;
    logic [511:0] block;
    logic [159:0] cv;
    eng_ctrl_t    ctrl;
    eng_stat_t    stat;
    logic         cv_init;
    logic         acc;

    rmd160_rounds u_rounds
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .ctrl    (ctrl),
        .cv_init (cv_init),
        .block   (block),
        .stat    (stat),
        .cv      (cv)
    );

    // Block buffer held as sixteen little-endian words.
    always_comb
    begin
        for (int i = 0; i < 16; i++)
            block[i*32 +: 32] = buf_reg[i];
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
            buf_reg[fill_reg[5:2]][{fill_reg[1:0], 3'd0} +: 8] <= wr_byte;
    end

    assign acc = s_tvalid && s_tready;

    // Sequencer.
    always_comb
    begin
        state_next    = state_reg;
        fill_next     = fill_reg;
        len_next      = len_reg;
        bits_next     = bits_reg;
        fin_next      = fin_reg;
        widx_next     = widx_reg;
        pad_live_next = pad_live_reg;
        pad_done_next = pad_done_reg;
        len_here_next = len_here_reg;
        wr_en         = 1'b0;
        wr_byte       = s_tdata;
        ctrl.start    = 1'b0;
        cv_init       = 1'b0;
        s_tready      = (state_reg == ST_IDLE);
        unique case (state_reg)
            ST_IDLE:
            begin
                if (acc)
                begin
                    bits_next = len_reg + (s_tuser ? 64'd8 : 64'd0);
                    len_next  = bits_next;
                    fin_next  = s_tlast;
                    if (s_tlast)
                    begin
                        pad_live_next = 1'b1;
                        pad_done_next = 1'b0;
                        len_here_next = 1'b0;
                    end
                    if (s_tuser)
                    begin
                        wr_en     = 1'b1;
                        fill_next = fill_reg + 6'd1;
                        if (fill_reg == 6'd63)
                        begin
                            ctrl.start = 1'b1;
                            state_next = ST_COMP;
                        end
                        else if (s_tlast)
                            state_next = ST_PAD;
                    end
                    else if (s_tlast)
                        state_next = ST_PAD;
                end
            end
            ST_PAD:
            begin
                // Pad byte: marker, zeros, then length little-endian.
                // The length goes in the block that holds the marker only when
                // the marker lands early enough; otherwise in the next block.
                wr_en = 1'b1;
                if (fin_reg)
                begin
                    wr_byte  = 8'h80;
                    fin_next = 1'b0;
                    if (fill_reg <= 6'd55)
                        len_here_next = 1'b1;
                end
                else if (len_here_reg && (fill_reg >= 6'd56))
                    wr_byte = bits_reg[{fill_reg[2:0], 3'd0} +: 8];
                else
                    wr_byte = 8'h00;
                fill_next = fill_reg + 6'd1;
                if (fill_reg == 6'd63)
                begin
                    ctrl.start = 1'b1;
                    state_next = ST_COMP;
                    if (len_here_reg && !fin_reg)
                        pad_done_next = 1'b1;
                end
            end
            ST_COMP:
            begin
                // After the fold: emit, pad a further block, or back to idle.
                if (stat.done)
                begin
                    if (pad_done_reg)
                        state_next = ST_EMIT;
                    else if (pad_live_reg)
                    begin
                        len_here_next = 1'b1;
                        state_next    = ST_PAD;
                    end
                    else
                        state_next = ST_IDLE;
                end
            end
            ST_EMIT:
            begin
                if (m_tready)
                begin
                    widx_next = widx_reg + 3'd1;
                    if (widx_reg == 3'd4)
                    begin
                        cv_init       = 1'b1;
                        widx_next     = 3'd0;
                        len_next      = '0;
                        pad_live_next = 1'b0;
                        pad_done_next = 1'b0;
                        len_here_next = 1'b0;
                        state_next    = ST_IDLE;
                    end
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // State and control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            fill_reg     <= '0;
            len_reg      <= '0;
            bits_reg     <= '0;
            fin_reg      <= 1'b0;
            widx_reg     <= '0;
            pad_live_reg <= 1'b0;
            pad_done_reg <= 1'b0;
            len_here_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            fill_reg     <= fill_next;
            len_reg      <= len_next;
            bits_reg     <= bits_next;
            fin_reg      <= fin_next;
            widx_reg     <= widx_next;
            pad_live_reg <= pad_live_next;
            pad_done_reg <= pad_done_next;
            len_here_reg <= len_here_next;
        end
    end

    // Digest word output.
    assign m_tvalid = (state_reg == ST_EMIT);
    assign m_tdata  = {5'd0, widx_reg, cv[{widx_reg, 5'd0} +: 32]};
    assign m_tlast  = (widx_reg == 3'd4);

    // The round unit runs throughout a compression until its fold.
    a_busy_comp: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_COMP && !stat.done) |-> stat.busy)
        else $error("round unit idle during compression");

    // No input word is taken while a digest is being emitted or a block compressed.
    a_no_accept: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_EMIT || state_reg == ST_COMP) |-> !s_tready)
        else $error("input accepted while busy");

    // The word index stays within the digest while output is valid.
    a_widx: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (widx_reg <= 3'd4))
        else $error("digest word index out of range");

endmodule

### tb/sv/tb.sv
// ----------------------------------------------------------------------------
// RIPEMD-160 hash core testbench
// Streams byte messages into the core with random gaps and output stalls,
// computes each digest with an independent model and checks every word.
// ----------------------------------------------------------------------------
module tb;

    import rmd160_pkg::*;

    logic        clk;
    logic        rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [7:0]  s_tdata;
    logic        s_tuser;
    logic        s_tlast;
    logic        m_tvalid;
    logic        m_tready;
    logic [39:0] m_tdata;
    logic        m_tlast;
    logic        s_tready_seen;

    // One input word: byte, byte-present flag, end of message.
    typedef struct packed {
        logic [7:0] data_byte;
        logic       has_byte;
        logic       last;
    } msg_word_t;

    // One digest word as the core should present it.
    typedef struct packed {
        logic [31:0] digest_word;
        logic [2:0]  word_index;
        logic        last_word;
    } digest_out_t;

    msg_word_t   pending_words[$];
    digest_out_t digest_queue[$];

    // Model state.
    logic [31:0] hash_chain [5];
    logic [7:0]  hash_block [64];
    int unsigned hash_fill;
    logic [63:0] hash_bits;

    int          error_count;
    int          cycle_count;
    bit          stimulus_done;
    bit          hold_sender;
    int          burst_left;
    int          gap_left;
    int          stall_phase;

    ripemd160_hash_core i_dut
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

    initial clk = 1'b0;
    always #2 clk = ~clk;

    function automatic logic [31:0] rol32(input logic [31:0] x, input int n);
        return (n == 0) ? x : ((x << n) | (x >> (32 - n)));
    endfunction

    function automatic logic [31:0] mix_fn(input int g, input logic [31:0] x,
                                           input logic [31:0] y, input logic [31:0] z);
        case (g)
            0: return x ^ y ^ z;
            1: return (x & y) | (~x & z);
            2: return (x | ~y) ^ z;
            3: return (x & z) | (y & ~z);
            default: return x ^ (y | ~z);
        endcase
    endfunction

    // Compress the held block into the chaining value.
    task automatic compress_block();
        int          sel_l [80];
        int          sel_r [80];
        int          sh_l [80];
        int          sh_r [80];
        logic [31:0] kl [5];
        logic [31:0] kr [5];
        logic [31:0] w [16];
        logic [31:0] a [5];
        logic [31:0] b [5];
        logic [31:0] t;
        int          g;
        sel_l = '{0,1,2,3,4,5,6,7,8,9,10,11,12,13,14,15,
                  7,4,13,1,10,6,15,3,12,0,9,5,2,14,11,8,
                  3,10,14,4,9,15,8,1,2,7,0,6,13,11,5,12,
                  1,9,11,10,0,8,12,4,13,3,7,15,14,5,6,2,
                  4,0,5,9,7,12,2,10,14,1,3,8,11,6,15,13};
        sel_r = '{5,14,7,0,9,2,11,4,13,6,15,8,1,10,3,12,
                  6,11,3,7,0,13,5,10,14,15,8,12,4,9,1,2,
                  15,5,1,3,7,14,6,9,11,8,12,2,10,0,4,13,
                  8,6,4,1,3,11,15,0,5,12,2,13,9,7,10,14,
                  12,15,10,4,1,5,8,7,6,2,13,14,0,3,9,11};
        sh_l = '{11,14,15,12,5,8,7,9,11,13,14,15,6,7,9,8,
                 7,6,8,13,11,9,7,15,7,12,15,9,11,7,13,12,
                 11,13,6,7,14,9,13,15,14,8,13,6,5,12,7,5,
                 11,12,14,15,14,15,9,8,9,14,5,6,8,6,5,12,
                 9,15,5,11,6,8,13,12,5,12,13,14,11,8,5,6};
        sh_r = '{8,9,9,11,13,15,15,5,7,7,8,11,14,14,12,6,
                 9,13,15,7,12,8,9,11,7,7,12,7,6,15,13,11,
                 9,7,15,11,8,6,6,14,12,13,5,14,13,13,7,5,
                 15,5,8,11,14,14,6,14,6,9,12,9,12,5,15,8,
                 8,5,12,9,12,5,14,6,8,13,6,5,15,13,11,11};
        kl = '{32'h00000000, 32'h5A827999, 32'h6ED9EBA1, 32'h8F1BBCDC, 32'hA953FD4E};
        kr = '{32'h50A28BE6, 32'h5C4DD124, 32'h6D703EF3, 32'h7A6D76E9, 32'h00000000};
        for (int j = 0; j < 16; j++)
            w[j] = {hash_block[4*j+3], hash_block[4*j+2], hash_block[4*j+1], hash_block[4*j]};
        a = hash_chain;
        b = hash_chain;
        for (int j = 0; j < 80; j++)
        begin
            g = j / 16;
            t = rol32(a[0] + mix_fn(g, a[1], a[2], a[3]) + w[sel_l[j]] + kl[g], sh_l[j]) + a[4];
            a[0] = a[4]; a[4] = a[3]; a[3] = rol32(a[2], 10); a[2] = a[1]; a[1] = t;
            t = rol32(b[0] + mix_fn(4 - g, b[1], b[2], b[3]) + w[sel_r[j]] + kr[g], sh_r[j])
                + b[4];
            b[0] = b[4]; b[4] = b[3]; b[3] = rol32(b[2], 10); b[2] = b[1]; b[1] = t;
        end
        t             = hash_chain[1] + a[2] + b[3];
        hash_chain[1] = hash_chain[2] + a[3] + b[4];
        hash_chain[2] = hash_chain[3] + a[4] + b[0];
        hash_chain[3] = hash_chain[4] + a[0] + b[1];
        hash_chain[4] = hash_chain[0] + a[1] + b[2];
        hash_chain[0] = t;
    endtask

    task automatic append_byte(input logic [7:0] v);
        hash_block[hash_fill] = v;
        hash_fill++;
        if (hash_fill == 64)
        begin
            compress_block();
            hash_fill = 0;
        end
    endtask

    task automatic restart_hash();
        hash_chain = '{IV0, IV1, IV2, IV3, IV4};
        hash_fill  = 0;
        hash_bits  = '0;
    endtask

    // Advance the model by one accepted word and queue any digest words.
    task automatic absorb_word(input msg_word_t mw);
        logic [63:0] len;
        if (mw.has_byte)
        begin
            append_byte(mw.data_byte);
            hash_bits += 64'd8;
        end
        if (mw.last)
        begin
            len = hash_bits;
            append_byte(8'h80);
            while (hash_fill != 56)
                append_byte(8'h00);
            for (int i = 0; i < 8; i++)
                append_byte(len[8*i +: 8]);
            for (int i = 0; i < 5; i++)
                digest_queue.push_back('{hash_chain[i], 3'(i), i == 4});
            restart_hash();
        end
    endtask

    task automatic queue_message(input int len, input bit empty_tail, input int pattern);
        msg_word_t mw;
        for (int i = 0; i < len; i++)
        begin
            case (pattern)
                1: mw.data_byte = 8'h00;
                2: mw.data_byte = 8'hFF;
                default: mw.data_byte = 8'($urandom_range(0, 255));
            endcase
            mw.has_byte = 1'b1;
            mw.last     = (i == len - 1) && !empty_tail;
            // Occasional empty non-final words that the core must ignore.
            if ($urandom_range(0, 15) == 0 && !mw.last)
                pending_words.push_back('{8'($urandom_range(0, 255)), 1'b0, 1'b0});
            pending_words.push_back(mw);
        end
        if (empty_tail || len == 0)
            pending_words.push_back('{8'($urandom_range(0, 255)), 1'b0, 1'b1});
    endtask

    // Stimulus: directed messages first, then random ones.
    initial
    begin
        int total;
        restart_hash();
        error_count   = 0;
        stimulus_done = 1'b0;
        hold_sender   = 1'b0;
        queue_message(0, 1'b1, 0);      // empty message
        queue_message(1, 1'b0, 1);      // single zero byte
        queue_message(1, 1'b0, 2);      // single 0xFF byte
        queue_message(3, 1'b1, 0);      // last word carries no byte
        queue_message(2, 1'b0, 0);
        queue_message(1, 1'b0, 0);
        queue_message(2, 1'b0, 0);
        queue_message(1, 1'b0, 0);
        total = pending_words.size();
        while (total < 470)
        begin
            int len;
            case ($urandom_range(0, 7))
                0: len = $urandom_range(55, 57);    // padding may spill to a second block
                1: len = $urandom_range(63, 65);    // block boundary
                2: len = $urandom_range(119, 129);
                default: len = $urandom_range(0, 20);
            endcase
            // Keep the total close to the intended item count.
            if (len > 470 - total)
                len = 470 - total;
            queue_message(len, $urandom_range(0, 3) == 0, 0);
            total = pending_words.size();
        end
        stimulus_done = 1'b1;
    end

    // Sender: bursts and gaps; halts once mid-run until all digests are out.
    always @(negedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s_tvalid   <= 1'b0;
            s_tdata    <= '0;
            s_tuser    <= 1'b0;
            s_tlast    <= 1'b0;
            burst_left <= 0;
            gap_left   <= 0;
        end
        else if (!s_tvalid || s_tready_seen)
        begin
            if (pending_words.size() == 150 && !hold_sender && digest_queue.size() != 0)
            begin
                s_tvalid <= 1'b0;
            end
            else if (gap_left > 0)
            begin
                s_tvalid <= 1'b0;
                gap_left <= gap_left - 1;
            end
            else if (pending_words.size() != 0)
            begin
                msg_word_t mw;
                mw = pending_words.pop_front();
                if (pending_words.size() == 149)
                    hold_sender <= 1'b1;
                s_tvalid <= 1'b1;
                s_tdata  <= mw.data_byte;
                s_tuser  <= mw.has_byte;
                s_tlast  <= mw.last;
                if (burst_left == 0)
                begin
                    burst_left <= $urandom_range(1, 40);
                    gap_left   <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
                end
                else
                    burst_left <= burst_left - 1;
            end
            else
                s_tvalid <= 1'b0;
        end
    end

    // Acceptance seen at the last rising edge.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s_tready_seen <= 1'b0;
        else
            s_tready_seen <= s_tvalid && s_tready;
    end

    // Receiver stall pattern.
    always @(negedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_tready    <= 1'b0;
            stall_phase <= 0;
        end
        else
        begin
            stall_phase <= stall_phase + 1;
            if (stall_phase[9:8] == 2'd3)
                m_tready <= 1'b1;
            else
                m_tready <= ($urandom_range(0, 3) != 0) && (stall_phase[4:2] != 3'd5);
        end
    end

    // Monitor: model on input acceptance, check on output acceptance.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (s_tvalid && s_tready)
                absorb_word('{s_tdata, s_tuser, s_tlast});
            if (m_tvalid && m_tready)
            begin
                if (digest_queue.size() == 0)
                begin
                    $error("unexpected digest word %h", m_tdata);
                    error_count++;
                end
                else
                begin
                    digest_out_t d;
                    d = digest_queue.pop_front();
                    if (m_tdata[31:0] !== d.digest_word)
                    begin
                        $error("digest_word: expected %h, got %h", d.digest_word, m_tdata[31:0]);
                        error_count++;
                    end
                    if (m_tdata[34:32] !== d.word_index)
                    begin
                        $error("word_index: expected %0d, got %0d", d.word_index, m_tdata[34:32]);
                        error_count++;
                    end
                    if (m_tlast !== d.last_word)
                    begin
                        $error("last_word: expected %b, got %b", d.last_word, m_tlast);
                        error_count++;
                    end
                end
            end
        end
    end

    // Reset, run, drain and verdict.
    initial
    begin
        rst_n       = 1'b0;
        cycle_count = 0;
        repeat (6) @(posedge clk);
        rst_n = 1'b1;
        while (!(stimulus_done && pending_words.size() == 0 && !s_tvalid
                 && digest_queue.size() == 0) && cycle_count < 400000)
        begin
            @(posedge clk);
            cycle_count++;
        end
        if (cycle_count >= 400000)
        begin
            $display("end of test: mismatches");
            $finish;
        end
        else
        begin
            repeat (200) @(posedge clk);
            if (error_count == 0 && digest_queue.size() == 0)
                $display("end of test: clean");
            else
                $display("end of test: mismatches");
            $finish;
        end
    end

endmodule
